// File: design/clook_pkg.sv
// Shared types and defaults for the C-LOOK request queue.
// Used by clook_cell and clook_request_queue_unit; no dependencies.
package clook_pkg;

  // Default sizes, handed down through the top-level parameters
  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_SECTOR_BITS = 48;
  localparam int DEF_TAG_BITS    = 8;

  localparam int FUNC_BITS   = 2;
  localparam int STATUS_BITS = 3;

  // Request function codes (s_tuser)
  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD      = 2'd0,
    FN_DISPATCH = 2'd1,
    FN_REMOVE   = 2'd2,
    FN_NONE     = 2'd3
  } func_t;

  // Result status codes (m_tuser)
  typedef enum logic [STATUS_BITS-1:0] {
    ST_ADDED      = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_IDLE       = 3'd2,
    ST_FULL       = 3'd3,
    ST_REMOVED    = 3'd4,
    ST_NOTFOUND   = 3'd5
  } status_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic add;      // insert the new request at its sorted place
    logic pop;      // dispatch: every cell takes its right neighbor
    logic rm;       // remove: cells at or past the first match shift left
    logic s_below;  // new sector lies below the head
  } cell_ctrl_t;

endpackage

// File: design/clook_cell.sv
// One slot of the sorted C-LOOK queue: holds a request and moves it to
// a neighbor on insert or delete. Depends on clook_pkg.
module clook_cell #(
  parameter int SECTOR_BITS = clook_pkg::DEF_SECTOR_BITS,
  parameter int TAG_BITS    = clook_pkg::DEF_TAG_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  clook_pkg::cell_ctrl_t     ctrl,
  input  logic [SECTOR_BITS-1:0]    head,
  input  logic [SECTOR_BITS-1:0]    ins_sector,
  input  logic                      ins_wr,
  input  logic [TAG_BITS-1:0]       ins_tag,
  input  logic                      rm_shift,
  // left neighbor
  input  logic                      left_cond,
  input  logic                      left_valid,
  input  logic [SECTOR_BITS-1:0]    left_sector,
  input  logic                      left_wr,
  input  logic [TAG_BITS-1:0]       left_tag,
  // right neighbor
  input  logic                      right_valid,
  input  logic [SECTOR_BITS-1:0]    right_sector,
  input  logic                      right_wr,
  input  logic [TAG_BITS-1:0]       right_tag,
  // this slot
  output logic                      valid,
  output logic [SECTOR_BITS-1:0]    sector,
  output logic                      wr,
  output logic [TAG_BITS-1:0]       tag,
  output logic                      cond,
  output logic                      match
);
  import clook_pkg::*;

  logic                   c_below;
  logic                   s_lt_c;
  logic                   valid_next;
  logic [SECTOR_BITS-1:0] sector_next;
  logic                   wr_next;
  logic [TAG_BITS-1:0]    tag_next;

  // Insert-here test; monotone along the chain, empty slots always pass
  always_comb begin
    c_below = sector < head;
    s_lt_c  = ins_sector < sector;
    cond    = !valid || (ctrl.s_below ? (c_below && s_lt_c) : (c_below || s_lt_c));
    match   = valid && (tag == ins_tag);
  end

  // Next slot contents
  always_comb begin
    valid_next  = valid;
    sector_next = sector;
    wr_next     = wr;
    tag_next    = tag;
    if (ctrl.add && cond) begin
      if (left_cond) begin
        valid_next  = left_valid;
        sector_next = left_sector;
        wr_next     = left_wr;
        tag_next    = left_tag;
      end else begin
        valid_next  = 1'b1;
        sector_next = ins_sector;
        wr_next     = ins_wr;
        tag_next    = ins_tag;
      end
    end else if (ctrl.pop || (ctrl.rm && rm_shift)) begin
      valid_next  = right_valid;
      sector_next = right_sector;
      wr_next     = right_wr;
      tag_next    = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    sector <= sector_next;
    wr     <= wr_next;
    tag    <= tag_next;
  end

endmodule

// File: design/clook_request_queue_unit.sv
// C-LOOK request queue top level: a chain of clook_cell slots, head
// register, fill count and registered result stage. Depends on clook_pkg.
//
// The queue keeps up to QUEUE_DEPTH requests in a row of cells sorted in
// C-LOOK order: requests at or above the head sector ascending, then those
// below it ascending. Each cell compares the new sector against its own
// entry, so an add, a dispatch or a remove by tag updates all cells at once;
// an item is accepted every cycle and its result appears in the output
// register on the next cycle. The only stall comes from the output
// register: a new transaction is taken when the result register is empty
// or is being drained in the same cycle. Remove locates the front-most
// matching tag with a log2(QUEUE_DEPTH)-level prefix-OR tree. After reset
// the queue is empty and the head sector is all ones; no clearing pass.
module clook_request_queue_unit #(
  parameter int QUEUE_DEPTH = clook_pkg::DEF_QUEUE_DEPTH,
  parameter int SECTOR_BITS = clook_pkg::DEF_SECTOR_BITS,
  parameter int TAG_BITS    = clook_pkg::DEF_TAG_BITS,
  localparam int IN_W  = ((SECTOR_BITS + 1 + TAG_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SECTOR_BITS + 2 + TAG_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [IN_W-1:0]                 s_tdata,  // sector, is_write, tag, zero pad
  input  logic [clook_pkg::FUNC_BITS-1:0] s_tuser,  // func
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_W-1:0]                m_tdata,  // out_sector, out_is_write,
                                                    // out_tag, queue_empty, zero pad
  output logic [clook_pkg::STATUS_BITS-1:0] m_tuser // status
);
  import clook_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LV    = $clog2(QUEUE_DEPTH);

  // Request fields
  logic                   accept;
  func_t                  func;
  logic [SECTOR_BITS-1:0] in_sector;
  logic                   in_wr;
  logic [TAG_BITS-1:0]    in_tag;

  // Queue state
  logic [SECTOR_BITS-1:0] head;
  logic [SECTOR_BITS-1:0] head_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   full;
  logic                   empty;
  cell_ctrl_t             ctrl;

  // Cell chain signals
  logic                   c_valid  [QUEUE_DEPTH];
  logic [SECTOR_BITS-1:0] c_sector [QUEUE_DEPTH];
  logic                   c_wr     [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    c_tag    [QUEUE_DEPTH];
  logic                   c_cond   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_match;
  logic [QUEUE_DEPTH-1:0] pre [LV+1];

  // Result
  status_t                status;
  logic [SECTOR_BITS-1:0] res_sector;
  logic                   res_wr;
  logic [TAG_BITS-1:0]    res_tag;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign func      = func_t'(s_tuser);
  assign in_sector = s_tdata[SECTOR_BITS-1:0];
  assign in_wr     = s_tdata[SECTOR_BITS];
  assign in_tag    = s_tdata[SECTOR_BITS+1 +: TAG_BITS];

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // Broadcast control
  always_comb begin
    ctrl.add     = accept && (func == FN_ADD) && !full;
    ctrl.pop     = accept && (func == FN_DISPATCH) && !empty;
    ctrl.rm      = accept && (func == FN_REMOVE);
    ctrl.s_below = in_sector < head;
  end

  // Prefix OR of tag matches: cells at or past the first match shift left
  assign pre[0] = c_match;
  for (genvar l = 0; l < LV; l++) begin : g_pre
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
      end else begin : g_pass
        assign pre[l+1][i] = pre[l][i];
      end
    end
  end

  // Cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   l_cond;
    logic                   l_valid;
    logic [SECTOR_BITS-1:0] l_sector;
    logic                   l_wr;
    logic [TAG_BITS-1:0]    l_tag;
    logic                   r_valid;
    logic [SECTOR_BITS-1:0] r_sector;
    logic                   r_wr;
    logic [TAG_BITS-1:0]    r_tag;

    if (i == 0) begin : g_first
      assign l_cond   = 1'b0;
      assign l_valid  = 1'b0;
      assign l_sector = '0;
      assign l_wr     = 1'b0;
      assign l_tag    = '0;
    end else begin : g_left
      assign l_cond   = c_cond[i-1];
      assign l_valid  = c_valid[i-1];
      assign l_sector = c_sector[i-1];
      assign l_wr     = c_wr[i-1];
      assign l_tag    = c_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_valid  = 1'b0;
      assign r_sector = '0;
      assign r_wr     = 1'b0;
      assign r_tag    = '0;
    end else begin : g_right
      assign r_valid  = c_valid[i+1];
      assign r_sector = c_sector[i+1];
      assign r_wr     = c_wr[i+1];
      assign r_tag    = c_tag[i+1];
    end

    clook_cell #(
      .SECTOR_BITS (SECTOR_BITS),
      .TAG_BITS    (TAG_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .head         (head),
      .ins_sector   (in_sector),
      .ins_wr       (in_wr),
      .ins_tag      (in_tag),
      .rm_shift     (pre[LV][i]),
      .left_cond    (l_cond),
      .left_valid   (l_valid),
      .left_sector  (l_sector),
      .left_wr      (l_wr),
      .left_tag     (l_tag),
      .right_valid  (r_valid),
      .right_sector (r_sector),
      .right_wr     (r_wr),
      .right_tag    (r_tag),
      .valid        (c_valid[i]),
      .sector       (c_sector[i]),
      .wr           (c_wr[i]),
      .tag          (c_tag[i]),
      .cond         (c_cond[i]),
      .match        (c_match[i])
    );
  end

  // Status, count and head update
  always_comb begin
    status     = ST_IDLE;
    count_next = count;
    head_next  = head;
    res_sector = '0;
    res_wr     = 1'b0;
    res_tag    = '0;
    case (func)
      FN_ADD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          status     = ST_ADDED;
          count_next = count + 1'b1;
        end
      end
      FN_DISPATCH: begin
        if (!empty) begin
          status     = ST_DISPATCHED;
          count_next = count - 1'b1;
          head_next  = c_sector[0];
          res_sector = c_sector[0];
          res_wr     = c_wr[0];
          res_tag    = c_tag[0];
        end
      end
      FN_REMOVE: begin
        if (pre[LV][QUEUE_DEPTH-1]) begin
          status     = ST_REMOVED;
          count_next = count - 1'b1;
        end else begin
          status = ST_NOTFOUND;
        end
      end
      default: begin
        status = ST_IDLE;
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      head     <= '1;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        head     <= head_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      m_tuser <= status;
      m_tdata <= OUT_W'({(count_next == '0), res_tag, res_wr, res_sector});
    end
  end

endmodule

// File: sim/clook_queue_checker.sv
`timescale 1ns / 1ps
// Checker for clook_request_queue_unit: watches the request and result streams,
// keeps its own C-LOOK queue and head position, and compares every result.
// Depends on clook_pkg.
module clook_queue_checker #(
  parameter int IN_W  = 64,
  parameter int OUT_W = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [IN_W-1:0]                   s_tdata,   // sector, is_write, tag, zero pad
  input  logic [clook_pkg::FUNC_BITS-1:0]   s_tuser,   // func
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [OUT_W-1:0]                  m_tdata,   // out_sector, out_is_write,
                                                       // out_tag, queue_empty, zero pad
  input  logic [clook_pkg::STATUS_BITS-1:0] m_tuser,   // status
  output int                                failures,
  output int                                backlog,
  output int                                full_rejects,
  output int                                dispatches,
  output int                                merges,
  output int                                misses,
  output int                                peak_depth
);
  import clook_pkg::*;

  localparam int QD   = DEF_QUEUE_DEPTH;
  localparam int SB   = DEF_SECTOR_BITS;
  localparam int TAGW = DEF_TAG_BITS;

  typedef struct packed {
    logic [SB-1:0]   sector;
    logic            wr;
    logic [TAGW-1:0] tag;
  } request_t;

  typedef struct packed {
    status_t         status;
    logic [SB-1:0]   sector;
    logic            wr;
    logic [TAGW-1:0] tag;
    logic            empty;
  } outcome_t;

  request_t      sweep_q[$];  // queued requests, front is the next to dispatch
  logic [SB-1:0] head_pos;    // sector of the last dispatch
  outcome_t      owed_q[$];   // results the block still has to deliver

  // Position for a new sector: ascending at/above head, then ascending below
  function automatic int slot_for(logic [SB-1:0] s);
    int i;
    for (i = 0; i < sweep_q.size(); i++) begin
      if (s < head_pos) begin
        if (sweep_q[i].sector < head_pos && s < sweep_q[i].sector) return i;
      end else begin
        if (sweep_q[i].sector < head_pos || s < sweep_q[i].sector) return i;
      end
    end
    return sweep_q.size();
  endfunction

  // Apply one request to the queue and return the result it should produce
  function automatic outcome_t schedule(func_t fn, request_t rq);
    outcome_t r;
    int hit;
    r = '0;
    r.status = ST_IDLE;
    case (fn)
      FN_ADD: begin
        if (sweep_q.size() >= QD) begin
          r.status = ST_FULL;
        end else begin
          sweep_q.insert(slot_for(rq.sector), rq);
          r.status = ST_ADDED;
        end
      end
      FN_DISPATCH: begin
        if (sweep_q.size() != 0) begin
          r.sector = sweep_q[0].sector;
          r.wr     = sweep_q[0].wr;
          r.tag    = sweep_q[0].tag;
          head_pos = sweep_q[0].sector;
          void'(sweep_q.pop_front());
          r.status = ST_DISPATCHED;
        end
      end
      FN_REMOVE: begin
        // front-most match wins when tags repeat
        hit = -1;
        for (int i = 0; i < sweep_q.size(); i++) begin
          if (sweep_q[i].tag == rq.tag) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          sweep_q.delete(hit);
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    r.empty = (sweep_q.size() == 0);
    return r;
  endfunction

  task automatic flag(string field, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      failures++;
      $display("[%0t] %s mismatch: expected %h, actual %h", $time, field, want, seen);
    end
  endtask

  // Result side is checked before the request side; the FIFO keeps them apart
  always @(posedge clk) begin
    request_t rq;
    outcome_t want;
    if (rst) begin
      sweep_q.delete();
      owed_q.delete();
      head_pos = '1;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_q.size() == 0) begin
          failures++;
          $display("[%0t] result transaction with nothing outstanding: expected none, actual status %0d tdata %h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = owed_q.pop_front();
          flag("status",       want.status, m_tuser);
          flag("out_sector",   want.sector, m_tdata[SB-1:0]);
          flag("out_is_write", want.wr,     m_tdata[SB]);
          flag("out_tag",      want.tag,    m_tdata[SB+TAGW:SB+1]);
          flag("queue_empty",  want.empty,  m_tdata[SB+TAGW+1]);
        end
      end
      if (s_tvalid && s_tready) begin
        rq.sector = s_tdata[SB-1:0];
        rq.wr     = s_tdata[SB];
        rq.tag    = s_tdata[SB+TAGW:SB+1];
        want = schedule(func_t'(s_tuser), rq);
        owed_q.push_back(want);
        case (want.status)
          ST_FULL:       full_rejects++;
          ST_DISPATCHED: dispatches++;
          ST_REMOVED:    merges++;
          ST_NOTFOUND:   misses++;
          default: ;
        endcase
        if (sweep_q.size() > peak_depth) peak_depth = sweep_q.size();
      end
    end
    backlog <= owed_q.size();
  end

endmodule

// File: sim/tb_clook_request_queue_unit.sv
`timescale 1ns / 1ps
// Testbench top for clook_request_queue_unit: drives request traffic and result
// backpressure, and takes the verdict from clook_queue_checker. Depends on clook_pkg.
module tb_clook_request_queue_unit;
  import clook_pkg::*;

  localparam int SB           = DEF_SECTOR_BITS;
  localparam int TAGW         = DEF_TAG_BITS;
  localparam int IN_W         = ((SB + 1 + TAGW + 7) / 8) * 8;
  localparam int OUT_W        = ((SB + 2 + TAGW + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic [FUNC_BITS-1:0]   s_tuser = FN_NONE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_W-1:0]       m_tdata;
  logic [STATUS_BITS-1:0] m_tuser;

  int   failures, backlog, full_rejects, dispatches, merges, misses, peak_depth;
  int   cycles = 0;
  int   sent = 0;
  int   directed = 0;
  int   rx_hold = 0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clook_request_queue_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  clook_queue_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .failures     (failures),
    .backlog      (backlog),
    .full_rejects (full_rejects),
    .dispatches   (dispatches),
    .merges       (merges),
    .misses       (misses),
    .peak_depth   (peak_depth)
  );

  // Result backpressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
      m_tready <= 1'b0;
      rx_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, backlog);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Optional idle gap ahead of the next request
  task automatic pause_tx();
    int n, r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // One request transaction; tvalid stays up for a back-to-back follower
  task automatic push_req(func_t fn, logic [SB-1:0] sec, logic wr, logic [TAGW-1:0] tg);
    pause_tx();
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= IN_W'({tg, wr, sec});
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Hold off until every result has been delivered
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  // Clusters near zero and near the top force ties and wraps around the head
  function automatic logic [SB-1:0] pick_sector();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return SB'($urandom_range(0, 63));
    if (r < 70) return SB'({$urandom, $urandom});
    if (r < 80) return {SB{1'b1}} - SB'($urandom_range(0, 63));
    if (r < 90) return '1;
    return '0;
  endfunction

  // Small tag pool so removes hit and duplicates occur
  function automatic logic [TAGW-1:0] pick_tag();
    if ($urandom_range(0, 99) < 70) return TAGW'($urandom_range(0, 15));
    return TAGW'($urandom_range(0, 255));
  endfunction

  function automatic func_t pick_func(phase_t m);
    int r, p_add, p_disp;
    r = $urandom_range(0, 99);
    case (m)
      PH_FILL: begin
        p_add  = 80;
        p_disp = 8;
      end
      PH_DRAIN: begin
        p_add  = 25;
        p_disp = 55;
      end
      default: begin
        p_add  = 45;
        p_disp = 35;
      end
    endcase
    if (r < p_add) return FN_ADD;
    if (r < p_add + p_disp) return FN_DISPATCH;
    if (r < 98) return FN_REMOVE;
    return FN_NONE;
  endfunction

  initial begin
    phase_t mode;
    int     span, phase_no;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, unused code, extremes, ties, duplicate tags, wrap
    push_req(FN_DISPATCH, '0, 1'b0, '0);         // nothing to dispatch
    push_req(FN_REMOVE, '0, 1'b0, '1);           // tag not found on empty queue
    push_req(FN_NONE, '1, 1'b1, '1);             // unused code
    push_req(FN_ADD, '0, 1'b0, '0);              // below the reset head
    push_req(FN_ADD, '1, 1'b1, '1);              // equal to the reset head
    push_req(FN_ADD, SB'(1000), 1'b1, TAGW'(5));
    push_req(FN_ADD, SB'(1000), 1'b0, TAGW'(5)); // same sector and tag again
    push_req(FN_ADD, SB'(500), 1'b0, TAGW'(9));
    push_req(FN_REMOVE, '0, 1'b0, TAGW'(5));     // front-most duplicate goes
    push_req(FN_DISPATCH, '0, 1'b0, '0);
    push_req(FN_DISPATCH, '0, 1'b0, '0);         // wraps to sector zero
    push_req(FN_ADD, '0, 1'b1, TAGW'(1));        // at the head
    push_req(FN_ADD, SB'(200), 1'b0, TAGW'(2));
    push_req(FN_DISPATCH, '0, 1'b0, '0);
    push_req(FN_DISPATCH, '0, 1'b0, '0);
    push_req(FN_ADD, SB'(100), 1'b1, TAGW'(3));  // below the head now
    push_req(FN_DISPATCH, '0, 1'b0, '0);
    push_req(FN_DISPATCH, '0, 1'b0, '0);
    push_req(FN_DISPATCH, '0, 1'b0, '0);
    push_req(FN_DISPATCH, '0, 1'b0, '0);         // queue already empty again
    push_req(FN_REMOVE, '0, 1'b0, TAGW'(3));
    directed = sent;
    settle();

    // Random phases; the first fills the queue past full
    phase_no = 0;
    while (sent < directed + RANDOM_ITEMS) begin
      mode = (phase_no == 0) ? PH_FILL : phase_t'($urandom_range(0, 2));
      span = (phase_no == 0) ? 150 : $urandom_range(60, 200);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 3) == 0);
      repeat (span) push_req(pick_func(mode), pick_sector(), 1'($urandom), pick_tag());
      if (phase_no == 0 || $urandom_range(0, 2) == 0) settle();
      phase_no++;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests: %0d directed, the rest in fill, drain and mixed phases",
             sent, directed);
    $display("with %0d dispatches, %0d full rejects, %0d merges, %0d tag misses, depth peak %0d",
             dispatches, full_rejects, merges, misses, peak_depth);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
